FILE: hdl/egr_pkg.sv
// Shared constants, types and the constant root table of the exponential gain ramp.
// Used by egr_div, exponential_gain_ramp_top and the testbench; depends on nothing.
package egr_pkg;

	localparam int LFRAC = 30;
	localparam int NUM_W = 36;
	localparam int DEN_W = 16;
	localparam int BLOCK_SAMPLES_DEF = 128;

	localparam logic [31:0] GAIN_ONE   = 32'd16777216;
	localparam logic [31:0] GAIN_FLOOR = 32'd168;
	localparam logic [47:0] STEP_ONE   = 48'h0001_0000_0000;
	localparam logic [47:0] STEP_MAX   = 48'hFFFF_FFFF_FFFF;

	typedef enum logic {
		CFG_TARGET_GAIN = 1'b0,
		CFG_RAMP_LENGTH = 1'b1
	} cfg_idx_t;

	typedef logic [31:0] roots_t [0:LFRAC];

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Roots of two in Q2.30: entry i is 2^(2^-i)
	function automatic roots_t gen_roots();
		roots_t t;
		logic [63:0] w;
		t[0] = 32'h8000_0000;
		for (int i = 1; i <= LFRAC; i++) begin
			w = isqrt64({32'd0, t[i-1]} << LFRAC);
			t[i] = w[31:0];
		end
		return t;
	endfunction

	localparam roots_t ROOTS = gen_roots();

endpackage

FILE: hdl/exponential_gain_ramp_top.sv
// Top level of the exponential gain ramp: sequencer, ramp state and ports.
// Depends on egr_pkg, egr_mul and egr_div.
//
// Each accepted sample is multiplied by the current Q8.24 gain, rounded half away
// from zero and saturated to 16 bits; the gain then takes one multiplicative ramp
// step. All products go through one shared 32x32 multiplier. At a block start
// (or an absent block, func=1) a new ramp may begin: its step is found by two
// 30-pass log2 squarings, a division by the ramp length and up to 30 root
// multiplies for exp2. An absent block advances the ramp by up to BLOCK_SAMPLES
// steps and gives no result. The input is ready only while the sequencer idles;
// a finished result sits in the output register and does not hold off the next
// transfer on the input side. Write configuration only while no item is in
// flight; it is sampled only at block starts and absent blocks.
module exponential_gain_ramp_top
	import egr_pkg::*;
#(
	parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] sample_in,
	input  logic               block_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_BEGIN, S_LOG_NORM, S_LOG_SQ, S_LOG_ACC, S_DIV_START, S_DIV_WAIT,
		S_EXP_INIT, S_EXP_ISSUE, S_EXP_ACC, S_EXP_FIN, S_ADV, S_GM1, S_GM2, S_GM3,
		S_SAMPLE_CHK, S_SCALE, S_OUT
	} state_t;

	state_t state_q;

	// configuration and ramp state
	logic [31:0] target_q;
	logic [15:0] len_q;
	logic [31:0] gain_q;
	logic [47:0] step_q;
	logic [15:0] left_q;
	logic [31:0] goal_q;
	logic        mute_q;

	// item and working registers
	logic               func_q;
	logic signed [15:0] samp_q;
	logic [31:0]        x_q;
	logic               lsel_q;
	logic [30:0]        m_q;
	logic [5:0]         p_q;
	logic [29:0]        frac_q;
	logic [4:0]         it_q;
	logic signed [36:0] le_q;
	logic signed [36:0] d_q;
	logic [31:0]        r_q;
	logic signed [6:0]  k_q;
	logic [29:0]        f_q;
	logic [31:0]        lo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [15:0] ypend_q;
	logic               out_valid_q;
	logic signed [15:0] out_q;

	// shared multiplier
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	egr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	// divider
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	egr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(len_q), .done(div_done), .quo(div_quo)
	);

	// combinational helpers
	logic [5:0]         msb;
	logic [30:0]        norm_m;
	logic [31:0]        sq_t;
	logic [NUM_W-1:0]   d_mag;
	logic signed [36:0] y_val;
	logic signed [7:0]  sh;
	logic [47:0]        exp_step;
	logic [16:0]        s_abs;
	logic [25:0]        sc_q;
	logic signed [15:0] sc_y;
	logic [63:0]        lo_sum;
	logic [48:0]        gm_v;
	logic [31:0]        gm_sat;
	logic               ret_true;
	logic [31:0]        ge;
	logic [31:0]        gs;

	assign in_ready   = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (x_q[i]) msb = 6'(i);
		end
	end

	always_comb begin
		if (msb >= 6'd30) norm_m = 31'(x_q >> (msb - 6'd30));
		else              norm_m = 31'(x_q << (6'd30 - msb));
	end

	assign sq_t    = mul_p[61:30];
	assign d_mag   = d_q[36] ? NUM_W'(-d_q) : NUM_W'(d_q);
	assign div_num = d_mag + NUM_W'(len_q >> 1);
	assign y_val   = d_q[36] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign sh      = 8'(k_q) + 8'sd2;

	always_comb begin
		if (sh >= 8'sd18)     exp_step = STEP_MAX;
		else if (sh >= 8'sd0) exp_step = {16'd0, r_q} << sh[4:0];
		else                  exp_step = {16'd0, r_q} >> 6'(-sh);
	end

	assign s_abs = samp_q[15] ? 17'(-{samp_q[15], samp_q}) : 17'({1'b0, samp_q});
	assign sc_q  = 26'((mul_p[48:0] + 49'h80_0000) >> 24);

	always_comb begin
		if (samp_q[15]) sc_y = (sc_q >= 26'd32768) ? -16'sd32768 : -$signed(sc_q[15:0]);
		else            sc_y = (sc_q >= 26'd32767) ? 16'sd32767 : $signed(sc_q[15:0]);
	end

	assign lo_sum = mul_p + 64'h8000_0000;
	assign gm_v   = mul_p[48:0] + 49'(lo_q);
	assign gm_sat = gm_v[48:32] != '0 ? 32'hFFFF_FFFF : gm_v[31:0];

	assign ret_true = (gain_q == target_q);
	assign ge       = (target_q != '0) ? target_q : GAIN_FLOOR;
	assign gs       = (gain_q != '0) ? gain_q : GAIN_FLOOR;
	assign div_start = (state_q == S_DIV_START);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_LOG_SQ: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			S_EXP_ISSUE: begin
				mul_a = r_q;
				mul_b = ROOTS[it_q + 5'd1];
			end
			S_GM1: begin
				mul_a = gain_q;
				mul_b = step_q[31:0];
			end
			S_GM2: begin
				mul_a = gain_q;
				mul_b = {16'd0, step_q[47:32]};
			end
			S_SAMPLE_CHK: begin
				mul_a = 32'(s_abs);
				mul_b = gain_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			target_q    <= GAIN_ONE;
			len_q       <= '0;
			gain_q      <= GAIN_ONE;
			step_q      <= STEP_ONE;
			left_q      <= '0;
			goal_q      <= GAIN_ONE;
			mute_q      <= 1'b0;
			out_valid_q <= 1'b0;
			it_q        <= '0;
			cnt_q       <= '0;
			lsel_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_TARGET_GAIN: target_q <= cfg_data;
					CFG_RAMP_LENGTH: len_q    <= cfg_data[15:0];
					default: ;
				endcase
			end
			// load a new result when the register frees up; drop the held one once it transfers
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						samp_q  <= sample_in;
						state_q <= (func || block_start) ? S_BEGIN : S_SAMPLE_CHK;
					end
				end
				S_BEGIN: begin
					// mute a sample block that starts with gain and target both zero
					mute_q <= ret_true && !func_q && (gain_q == '0);
					cnt_q  <= '0;
					if (ret_true) begin
						left_q <= '0;
						if (func_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SAMPLE_CHK;
						end
					end else if (left_q == '0 || target_q != goal_q) begin
						goal_q <= target_q;
						if (len_q == '0) begin
							gain_q  <= target_q;
							step_q  <= STEP_ONE;
							left_q  <= '0;
							state_q <= func_q ? S_ADV : S_SAMPLE_CHK;
						end else begin
							if (gain_q == '0) gain_q <= GAIN_FLOOR;
							left_q  <= len_q;
							x_q     <= ge;
							lsel_q  <= 1'b0;
							state_q <= S_LOG_NORM;
						end
					end else begin
						state_q <= func_q ? S_ADV : S_SAMPLE_CHK;
					end
				end
				S_LOG_NORM: begin
					m_q     <= norm_m;
					p_q     <= msb;
					it_q    <= '0;
					state_q <= S_LOG_SQ;
				end
				S_LOG_SQ: state_q <= S_LOG_ACC;
				S_LOG_ACC: begin
					m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
					frac_q <= {frac_q[28:0], sq_t[31]};
					if (it_q == 5'd29) begin
						if (!lsel_q) begin
							le_q    <= {7'(p_q) - 7'sd24, frac_q[28:0], sq_t[31]};
							x_q     <= gs;
							lsel_q  <= 1'b1;
							state_q <= S_LOG_NORM;
						end else begin
							d_q     <= le_q - {7'(p_q) - 7'sd24, frac_q[28:0], sq_t[31]};
							state_q <= S_DIV_START;
						end
					end else begin
						it_q    <= it_q + 5'd1;
						state_q <= S_LOG_SQ;
					end
				end
				S_DIV_START: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: if (div_done) state_q <= S_EXP_INIT;
				S_EXP_INIT: begin
					k_q     <= y_val[36:30];
					f_q     <= y_val[29:0];
					r_q     <= 32'h4000_0000;
					it_q    <= '0;
					state_q <= S_EXP_ISSUE;
				end
				S_EXP_ISSUE: begin
					if (f_q[5'd29 - it_q]) begin
						state_q <= S_EXP_ACC;
					end else if (it_q == 5'd29) begin
						state_q <= S_EXP_FIN;
					end else begin
						it_q <= it_q + 5'd1;
					end
				end
				S_EXP_ACC: begin
					r_q <= mul_p[61:30];
					if (it_q == 5'd29) begin
						state_q <= S_EXP_FIN;
					end else begin
						it_q    <= it_q + 5'd1;
						state_q <= S_EXP_ISSUE;
					end
				end
				S_EXP_FIN: begin
					step_q  <= exp_step;
					state_q <= func_q ? S_ADV : S_SAMPLE_CHK;
				end
				S_ADV: begin
					if (cnt_q == CNT_W'(BLOCK_SAMPLES) || left_q == '0) state_q <= S_IDLE;
					else                                               state_q <= S_GM1;
				end
				S_GM1: state_q <= S_GM2;
				S_GM2: begin
					lo_q    <= lo_sum[63:32];
					state_q <= S_GM3;
				end
				S_GM3: begin
					// advance one ramp step; land exactly on the goal at the end
					left_q <= left_q - 16'd1;
					gain_q <= (left_q == 16'd1) ? goal_q : gm_sat;
					if (func_q) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_ADV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SAMPLE_CHK: state_q <= mute_q ? S_IDLE : S_SCALE;
				S_SCALE: begin
					ypend_q <= sc_y;
					state_q <= (left_q != '0) ? S_GM1 : S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_q   <= ypend_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_land_on_goal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GM3 && left_q == 16'd1) |=> (gain_q == goal_q && left_q == '0))
		else $error("ramp did not land on goal");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_mute_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SAMPLE_CHK && mute_q) |=> (state_q == S_IDLE))
		else $error("muted sample went on to scaling");

	a_adv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADV) |-> (cnt_q <= CNT_W'(BLOCK_SAMPLES)))
		else $error("absent block advanced too far");

endmodule

FILE: hdl/egr_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing outside this file.
module egr_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

FILE: hdl/egr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on egr_pkg for operand widths.
module egr_div
	import egr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for exponential_gain_ramp_top: an internal gain/ramp predictor
// checks every output sample under random idling on the input and output sides.
// Depends on egr_pkg and the RTL of the exponential gain ramp.
module testbench
	import egr_pkg::*;
();

	localparam int BLOCK_LEN   = 128;
	localparam int SETTLE_CYC  = 1000;
	localparam int CYCLE_LIMIT = 2000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               func;
	logic signed [15:0] sample_in;
	logic               block_start;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample_out;
	logic               cfg_valid;
	logic               cfg_ready;
	cfg_idx_t           cfg_index;
	logic [31:0]        cfg_data;

	exponential_gain_ramp_top #(.BLOCK_SAMPLES(BLOCK_LEN)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .sample_in(sample_in), .block_start(block_start),
		.out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Gain model state, computed independently of the block's own registers
	logic [31:0] mdl_target;
	logic [15:0] mdl_length;
	logic [31:0] mdl_gain;
	logic [63:0] mdl_step;
	logic [15:0] mdl_left;
	logic [31:0] mdl_goal;
	bit          mdl_mute;
	logic [63:0] root_tbl [0:LFRAC];

	logic signed [15:0] scaled_q[$];   // expected output samples, oldest first
	int  errors, n_items, n_samples, n_absent, n_checked, cycles;
	bit  quiet;                        // no idling on either side

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------- predictor ----------------
	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v, r, b;
		v = v_in; r = 0; b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q.30 log2 of a nonzero Q8.24 gain
	function automatic longint log2_gain(input logic [31:0] x);
		int p;
		logic [63:0] m, frac;
		p = 31; frac = 0;
		while (p > 0 && x[p] == 1'b0) p--;
		if (p >= 30) m = {32'd0, x} >> (p - 30);
		else m = {32'd0, x} << (30 - p);
		for (int i = 1; i <= LFRAC; i++) begin
			m = (m * m) >> LFRAC;
			if (m >= (64'd2 << LFRAC)) begin
				frac[LFRAC - i] = 1'b1;
				m = m >> 1;
			end
		end
		return longint'(p - 24) * (longint'(1) << LFRAC) + longint'(frac);
	endfunction

	// 2^y, Q16.32 saturated to 48 bits
	function automatic logic [63:0] pow2_step(input longint y);
		logic [63:0] ys, f, r;
		int k, sh;
		r = 64'd1 << LFRAC;
		ys = y + 64 * (longint'(1) << LFRAC);
		k = int'(ys >> LFRAC) - 64;
		f = ys & ((64'd1 << LFRAC) - 1);
		for (int i = 1; i <= LFRAC; i++)
			if (f[LFRAC - i]) r = (r * root_tbl[i]) >> LFRAC;
		sh = k + 2;
		if (sh >= 18) return {16'd0, STEP_MAX};
		if (sh >= 0) return r << sh;
		if (-sh > 63) return 0;
		return r >> (-sh);
	endfunction

	function automatic logic [63:0] ramp_ratio(input logic [31:0] g_end, g_start,
		input logic [15:0] n);
		longint d;
		logic [63:0] mag, q;
		d = log2_gain(g_end) - log2_gain(g_start);
		mag = d < 0 ? -d : d;
		q = (mag + n / 2) / n;
		return pow2_step(d < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic logic [31:0] gain_times_step(input logic [31:0] g, input logic [63:0] s);
		logic [63:0] lo, v;
		lo = ({32'd0, g} * {32'd0, s[31:0]} + 64'h8000_0000) >> 32;
		v = {32'd0, g} * (s >> 32) + lo;
		return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic void step_gain();
		if (mdl_left > 0) begin
			mdl_gain = gain_times_step(mdl_gain, mdl_step);
			mdl_left--;
			if (mdl_left == 0) mdl_gain = mdl_goal;
		end
	endfunction

	function automatic logic signed [15:0] apply_gain(input logic signed [15:0] s,
		input logic [31:0] g);
		logic [63:0] mag, q;
		mag = (s < 0 ? -longint'(s) : longint'(s)) * {32'd0, g};
		q = (mag + (64'd1 << 23)) >> 24;
		if (s < 0) return q >= 32768 ? -16'sd32768 : -$signed(q[15:0]);
		return q >= 32767 ? 16'sd32767 : $signed(q[15:0]);
	endfunction

	// Block-start decision: returns 1 when the gain already sits at the target
	function automatic bit open_block();
		mdl_mute = 0;
		if (mdl_gain == mdl_target) begin
			mdl_left = 0;
			return 1;
		end
		if (mdl_left == 0 || mdl_target != mdl_goal) begin
			mdl_goal = mdl_target;
			if (mdl_length == 0) begin
				mdl_gain = mdl_target;
				mdl_step = {16'd0, STEP_ONE};
				mdl_left = 0;
			end else begin
				mdl_step = ramp_ratio(mdl_target ? mdl_target : GAIN_FLOOR,
					mdl_gain ? mdl_gain : GAIN_FLOOR, mdl_length);
				if (mdl_gain == 0) mdl_gain = GAIN_FLOOR;
				mdl_left = mdl_length;
			end
		end
		return 0;
	endfunction

	// Advance the model by one accepted item; queue the output sample if one is due
	function automatic void predict_item(input logic f, input logic signed [15:0] s,
		input logic bs);
		if (f) begin
			n_absent++;
			if (!open_block())
				for (int i = 0; i < BLOCK_LEN && mdl_left > 0; i++) step_gain();
			return;
		end
		if (bs && open_block() && mdl_gain == 0) mdl_mute = 1;
		if (mdl_mute) return;
		scaled_q.push_back(apply_gain(s, mdl_gain));
		step_gain();
	endfunction

	// ---------------- output side ----------------
	// Stall in random bursts unless quiet
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (scaled_q.size() == 0) begin
				$display("%0t: unexpected sample_out %0d", $time, sample_out);
				errors++;
			end else begin
				if (sample_out !== scaled_q[0]) begin
					$display("%0t: sample_out expected %0d actual %0d",
						$time, scaled_q[0], sample_out);
					errors++;
				end
				void'(scaled_q.pop_front());
				n_checked++;
			end
		end
	end

	// ---------------- input side ----------------
	// Send one item, optionally after an idle burst; valid stays high on return
	task automatic send_item(input logic f, input logic signed [15:0] s, input logic bs);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		sample_in   <= s;
		block_start <= bs;
		do @(posedge clk); while (!in_ready);
		predict_item(f, s, bs);
		n_items++;
		if (!f) n_samples++;
	endtask

	// Hold input off until every queued sample has come out, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (scaled_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_TARGET_GAIN) mdl_target = val;
		else mdl_length = val[15:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_ramp(input logic [31:0] tgt, input logic [15:0] len);
		drain();
		write_reg(CFG_TARGET_GAIN, tgt);
		write_reg(CFG_RAMP_LENGTH, {16'd0, len});
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return $signed(16'($urandom_range(0, 3)) - 16'd1);
			default: return $signed(16'($urandom));
		endcase
	endfunction

	// ---------------- tests ----------------
	// Unity gain after reset: samples pass unchanged, extremes included
	task automatic test_unity_pass();
		send_item(1'b0, 16'sh7FFF, 1'b1);
		send_item(1'b0, -16'sh8000, 1'b0);
		send_item(1'b0, 16'sd0, 1'b0);
		send_item(1'b0, 16'sd1, 1'b0);
		send_item(1'b0, -16'sd1, 1'b0);
	endtask

	// Immediate switches: saturation at high gain, zero gain, muted block, absent block
	task automatic test_switch_and_mute();
		set_ramp(32'hFFFF_FFFF, 16'd0);
		send_item(1'b0, 16'sh7FFF, 1'b1);
		send_item(1'b0, -16'sh8000, 1'b0);
		send_item(1'b0, 16'sd3, 1'b0);
		set_ramp(32'd0, 16'd0);
		send_item(1'b0, 16'sd1000, 1'b1);    // switches to zero, still gives a sample
		send_item(1'b0, 16'sd1000, 1'b1);    // gain and target both zero: muted
		send_item(1'b0, -16'sd5, 1'b0);
		send_item(1'b1, 16'sd0, 1'b0);       // absent block clears the mute
		send_item(1'b0, 16'sd7, 1'b0);
	endtask

	// Ramps: up from zero via the floor, to max with the longest length, and a change
	// of target while a ramp runs, read at the next block start only
	task automatic test_ramps();
		set_ramp(GAIN_ONE, 16'd16);
		for (int i = 0; i < 6; i++) send_item(1'b0, 16'sd20000, i == 0);
		send_item(1'b1, 16'sd0, 1'b0);
		set_ramp(32'hFFFF_FFFF, 16'hFFFF);
		send_item(1'b0, -16'sd12345, 1'b1);
		send_item(1'b1, 16'sd0, 1'b0);
		set_ramp(32'd0, 16'd1);
		send_item(1'b0, 16'sh7FFF, 1'b0);    // no block start: old ramp continues
		send_item(1'b0, 16'sh7FFF, 1'b1);
		send_item(1'b0, 16'sh7FFF, 1'b0);
	endtask

	// Random phases of blocks, mostly well-formed, with absent blocks and missing starts
	task automatic test_random_blocks();
		logic [31:0] tgt;
		logic [15:0] len;
		int blen;
		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 6))
				0: tgt = 0;
				1: tgt = GAIN_ONE;
				2: tgt = $urandom;
				3: tgt = 32'hFFFF_FFFF;
				default: tgt = $urandom_range(1 << 20, 1 << 27);
			endcase
			case ($urandom_range(0, 5))
				0: len = 0;
				1: len = 16'hFFFF;
				default: len = $urandom_range(1, 300);
			endcase
			set_ramp(tgt, len);
			quiet = (ph >= 10);
			for (int k = 0; k < 65; ) begin
				if ($urandom_range(0, 15) == 0) begin
					send_item(1'b1, $signed(16'($urandom)), 1'($urandom));
					k++;
				end else begin
					blen = $urandom_range(1, 40);
					for (int j = 0; j < blen; j++)
						send_item(1'b0, rand_sample(),
							j == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0));
					k += blen;
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0; arst_n = 1'b0;
		in_valid = 1'b0; func = 1'b0; sample_in = '0; block_start = 1'b0;
		cfg_valid = 1'b0; cfg_index = CFG_TARGET_GAIN; cfg_data = '0;
		errors = 0; n_items = 0; n_samples = 0; n_absent = 0; n_checked = 0;
		cycles = 0; quiet = 0;
		root_tbl[0] = 64'd2 << LFRAC;
		for (int i = 1; i <= LFRAC; i++) root_tbl[i] = int_sqrt(root_tbl[i - 1] << LFRAC);
		mdl_target = GAIN_ONE; mdl_length = 0; mdl_gain = GAIN_ONE;
		mdl_step = {16'd0, STEP_ONE}; mdl_left = 0; mdl_goal = GAIN_ONE; mdl_mute = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_unity_pass();
		test_switch_and_mute();
		test_ramps();
		test_random_blocks();

		drain();
		$display("Sent %0d items (%0d samples, %0d absent blocks), checked %0d outputs",
			n_items, n_samples, n_absent, n_checked);
		$display("Covered unity, saturation, zero-gain mute, floor ramps and random configs");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
